FILE: sv/urr_pkg.sv
// Shared types and register map constants for the UART register model with receive ring.
package urr_pkg;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_PUSH  = 2'd2;

	localparam logic [2:0] REG_RBR = 3'd0;
	localparam logic [2:0] REG_IER = 3'd1;
	localparam logic [2:0] REG_IIR = 3'd2;
	localparam logic [2:0] REG_LCR = 3'd3;
	localparam logic [2:0] REG_MCR = 3'd4;
	localparam logic [2:0] REG_LSR = 3'd5;
	localparam logic [2:0] REG_MSR = 3'd6;
	localparam logic [2:0] REG_SCR = 3'd7;

	localparam int unsigned LCR_DLAB  = 7;
	localparam int unsigned IER_RDI   = 0;
	localparam int unsigned IER_THRI  = 1;
	localparam int unsigned FCR_EN    = 0;

	localparam logic [7:0] IIR_RDI    = 8'h04;
	localparam logic [7:0] IIR_THRI   = 8'h02;
	localparam logic [7:0] IIR_NONE   = 8'h01;
	localparam logic [7:0] IIR_FIFO   = 8'hC0;
	localparam logic [7:0] LSR_DR     = 8'h01;
	localparam logic [7:0] LSR_THRE   = 8'h20;
	localparam logic [7:0] LSR_TEMT   = 8'h40;
	localparam logic [7:0] MSR_FIXED  = 8'hB0;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] reg_offset;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_level;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_overflow;
	} rsp_t;

endpackage

FILE: sv/urr_if.sv
// Valid/ready channels for bus and line items and for their results.
interface urr_req_if;
	import urr_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface urr_rsp_if;
	import urr_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: sv/urr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module urr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: sv/uart_register_model_rx_ring.sv
// 8250-style UART register file with a receive ring; top level.
// Channel req carries one item per transfer: a bus read (mode 0), a bus write
// (mode 1) or a byte received from the line (mode 2) that goes into the ring.
// Mode 3 does nothing but report the current interrupt level.
// Channel rsp returns exactly one result per item, in order: read data, the
// interrupt level after the item, the byte sent by a THR write, and a flag
// for a received byte dropped on a full ring.
// An item taken from req is registered in the execute stage, executed there,
// and its result is registered in the result stage. Throughput: one item per
// cycle while rsp does not stall. The stage behind the input register holds
// all register updates; the ring lives in a RAM whose registered read port
// delivers RBR data straight into the result stage.
// The ring holds up to RX_DEPTH-1 bytes; an RBR read on an empty ring gives 0.
// Reset clears all registers and both ring pointers at once; ring contents
// are not cleared and need not be, since only filled slots are read.
// When rsp stalls the result stage holds, the execute stage waits behind it
// and req.ready drops once both are full; nothing is lost or repeated.
module uart_register_model_rx_ring #(
	parameter int RX_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	urr_req_if.sink   req,
	urr_rsp_if.source rsp
);
	import urr_pkg::*;

	localparam int PTR_W = $clog2(RX_DEPTH);

	// execute stage
	logic       valid_s1;
	req_t       req_s1;
	logic       adv_s1;

	// architectural state
	logic [7:0]       ier_q, lcr_q, mcr_q, scr_q, fcr_q;
	logic [15:0]      div_q;
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;

	// next state
	logic [7:0]       ier_n, lcr_n, mcr_n, scr_n, fcr_n;
	logic [15:0]      div_n;
	logic [PTR_W-1:0] wr_ptr_n, rd_ptr_n;
	logic [PTR_W-1:0] wr_next, rd_next;

	logic       dlab, has_data;
	logic [7:0] rd_val;
	logic       ram_sel, ram_we;
	logic       txv, ovf, irq_n;
	logic [7:0] iir_val;

	// result stage
	logic       valid_s2;
	logic       ram_sel_s2;
	rsp_t       rsp_s2;
	logic [7:0] ram_rdata;

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.payload;
		end
	end

	assign dlab     = lcr_q[LCR_DLAB];
	assign has_data = wr_ptr_q != rd_ptr_q;
	assign wr_next  = (wr_ptr_q == PTR_W'(RX_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_next  = (rd_ptr_q == PTR_W'(RX_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	always_comb begin
		priority if (ier_q[IER_RDI] && has_data) begin
			iir_val = IIR_RDI;
		end else if (ier_q[IER_THRI]) begin
			iir_val = IIR_THRI;
		end else begin
			iir_val = IIR_NONE;
		end
		if (fcr_q[FCR_EN]) begin
			iir_val = iir_val | IIR_FIFO;
		end
	end

	always_comb begin
		ier_n    = ier_q;
		lcr_n    = lcr_q;
		mcr_n    = mcr_q;
		scr_n    = scr_q;
		fcr_n    = fcr_q;
		div_n    = div_q;
		wr_ptr_n = wr_ptr_q;
		rd_ptr_n = rd_ptr_q;
		rd_val   = 8'h00;
		ram_sel  = 1'b0;
		ram_we   = 1'b0;
		txv      = 1'b0;
		ovf      = 1'b0;
		unique case (req_s1.mode)
			MODE_READ: begin
				unique case (req_s1.reg_offset)
					REG_RBR: begin
						if (dlab) begin
							rd_val = div_q[7:0];
						end else if (has_data) begin
							// data comes from the RAM read port next cycle
							ram_sel  = 1'b1;
							rd_ptr_n = rd_next;
						end
					end
					REG_IER: rd_val = dlab ? div_q[15:8] : ier_q;
					REG_IIR: rd_val = iir_val;
					REG_LCR: rd_val = lcr_q;
					REG_MCR: rd_val = mcr_q;
					REG_LSR: rd_val = (has_data ? LSR_DR : 8'h00) | LSR_THRE | LSR_TEMT;
					REG_MSR: rd_val = MSR_FIXED;
					REG_SCR: rd_val = scr_q;
				endcase
			end
			MODE_WRITE: begin
				unique case (req_s1.reg_offset)
					REG_RBR: begin
						if (dlab) begin
							div_n[7:0] = req_s1.data_byte;
						end else begin
							txv = 1'b1;
						end
					end
					REG_IER: begin
						if (dlab) begin
							div_n[15:8] = req_s1.data_byte;
						end else begin
							ier_n = req_s1.data_byte;
						end
					end
					REG_IIR: fcr_n = req_s1.data_byte;
					REG_LCR: lcr_n = req_s1.data_byte;
					REG_MCR: mcr_n = req_s1.data_byte;
					REG_LSR, REG_MSR: begin
					end
					REG_SCR: scr_n = req_s1.data_byte;
				endcase
			end
			MODE_PUSH: begin
				// drop the byte when the ring is full
				if (wr_next == rd_ptr_q) begin
					ovf = 1'b1;
				end else begin
					ram_we   = 1'b1;
					wr_ptr_n = wr_next;
				end
			end
			default: begin
			end
		endcase
		irq_n = (ier_n[IER_RDI] && (wr_ptr_n != rd_ptr_n)) || ier_n[IER_THRI];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ier_q    <= '0;
			lcr_q    <= '0;
			mcr_q    <= '0;
			scr_q    <= '0;
			fcr_q    <= '0;
			div_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (adv_s1) begin
			ier_q    <= ier_n;
			lcr_q    <= lcr_n;
			mcr_q    <= mcr_n;
			scr_q    <= scr_n;
			fcr_q    <= fcr_n;
			div_q    <= div_n;
			wr_ptr_q <= wr_ptr_n;
			rd_ptr_q <= rd_ptr_n;
		end
	end

	urr_ram #(
		.WIDTH(8),
		.DEPTH(RX_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (adv_s1 && ram_we),
		.waddr(wr_ptr_q),
		.wdata(req_s1.data_byte),
		.re   (adv_s1 && ram_sel),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ram_sel_s2          <= ram_sel;
			rsp_s2.read_data    <= rd_val;
			rsp_s2.irq_level    <= irq_n;
			rsp_s2.tx_valid     <= txv;
			rsp_s2.tx_byte      <= txv ? req_s1.data_byte : 8'h00;
			rsp_s2.rx_overflow  <= ovf;
		end
	end

	assign rsp.valid = valid_s2;
	always_comb begin
		rsp.payload = rsp_s2;
		if (ram_sel_s2) begin
			rsp.payload.read_data = ram_rdata;
		end
	end

`ifndef SYNTHESIS
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && ram_we |-> wr_next != rd_ptr_q)
		else $error("ring write would overrun the read pointer");

	a_ram_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && ram_sel |-> has_data && !dlab)
		else $error("ring read issued on an empty ring or with DLAB set");

	a_adv_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("executed item did not reach the result stage");

	a_ovf_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.rx_overflow |-> !rsp_s2.tx_valid && !ram_sel_s2)
		else $error("overflow result mixed with a send or a ring read");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q <= PTR_W'(RX_DEPTH - 1)) && (rd_ptr_q <= PTR_W'(RX_DEPTH - 1)))
		else $error("ring pointer out of range");
`endif
endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the UART register file with receive ring.
`timescale 1ns / 100ps

module tb_top;
	import urr_pkg::*;

	localparam int RING_DEPTH = 64;
	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int RANDOM_ITEMS = 1900;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 10;
	localparam int PRINT_CAP = 40;

	logic clk;
	logic arst_n;

	urr_req_if req_ch ();
	urr_rsp_if rsp_ch ();

	uart_register_model_rx_ring #(.RX_DEPTH(RING_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// predicted register state
	logic [7:0]       irq_en;
	logic [7:0]       line_ctl;
	logic [7:0]       modem_ctl;
	logic [7:0]       scratch_reg;
	logic [7:0]       fifo_ctl;
	logic [15:0]      divisor;
	logic [7:0]       rx_ring [RING_DEPTH];
	logic [PTR_W-1:0] ring_wr;
	logic [PTR_W-1:0] ring_rd;

	req_t pending_items[$];
	rsp_t expected_results[$];

	int error_count = 0;
	int result_count = 0;
	int accepted_items;
	int send_gap;
	int stall_left;
	int hold_left;
	int cycle_count = 0;
	bit hold_done;
	bit send_fast;
	bit recv_fast;

	function automatic logic irq_line();
		return (irq_en[IER_RDI] && ring_wr != ring_rd) || irq_en[IER_THRI];
	endfunction

	function automatic rsp_t uart_predict(req_t item);
		rsp_t res;
		logic dlab;
		logic [PTR_W-1:0] next_wr;
		res = '0;
		dlab = line_ctl[LCR_DLAB];
		case (item.mode)
		MODE_READ: begin
			case (item.reg_offset)
			REG_RBR: begin
				if (dlab) begin
					res.read_data = divisor[7:0];
				end else if (ring_wr != ring_rd) begin
					res.read_data = rx_ring[ring_rd];
					ring_rd = ring_rd + 1'b1;
				end
			end
			REG_IER: res.read_data = dlab ? divisor[15:8] : irq_en;
			REG_IIR: begin
				if (irq_en[IER_RDI] && ring_wr != ring_rd)
					res.read_data = IIR_RDI;
				else if (irq_en[IER_THRI])
					res.read_data = IIR_THRI;
				else
					res.read_data = IIR_NONE;
				if (fifo_ctl[FCR_EN])
					res.read_data = res.read_data | IIR_FIFO;
			end
			REG_LCR: res.read_data = line_ctl;
			REG_MCR: res.read_data = modem_ctl;
			REG_LSR: res.read_data = ((ring_wr != ring_rd) ? LSR_DR : 8'h00)
				| LSR_THRE | LSR_TEMT;
			REG_MSR: res.read_data = MSR_FIXED;
			default: res.read_data = scratch_reg;
			endcase
		end
		MODE_WRITE: begin
			case (item.reg_offset)
			REG_RBR: begin
				if (dlab) begin
					divisor[7:0] = item.data_byte;
				end else begin
					res.tx_valid = 1'b1;
					res.tx_byte = item.data_byte;
				end
			end
			REG_IER: begin
				if (dlab)
					divisor[15:8] = item.data_byte;
				else
					irq_en = item.data_byte;
			end
			REG_IIR: fifo_ctl = item.data_byte;
			REG_LCR: line_ctl = item.data_byte;
			REG_MCR: modem_ctl = item.data_byte;
			REG_SCR: scratch_reg = item.data_byte;
			default: ;
			endcase
		end
		MODE_PUSH: begin
			next_wr = ring_wr + 1'b1;
			if (next_wr == ring_rd) begin
				res.rx_overflow = 1'b1;
			end else begin
				rx_ring[ring_wr] = item.data_byte;
				ring_wr = next_wr;
			end
		end
		default: ;
		endcase
		res.irq_level = irq_line();
		return res;
	endfunction

	// predicted state resets with the block
	task automatic reset_model();
		irq_en = '0;
		line_ctl = '0;
		modem_ctl = '0;
		scratch_reg = '0;
		fifo_ctl = '0;
		divisor = '0;
		ring_wr = '0;
		ring_rd = '0;
		for (int i = 0; i < RING_DEPTH; i++)
			rx_ring[i] = '0;
	endtask

	function automatic req_t bus_item(logic [1:0] mode, logic [2:0] offset, logic [7:0] data);
		req_t item;
		item.mode = mode;
		item.reg_offset = offset;
		item.data_byte = data;
		return item;
	endfunction

	task automatic add_item(logic [1:0] mode, logic [2:0] offset, logic [7:0] data);
		pending_items.push_back(bus_item(mode, offset, data));
	endtask

	task automatic add_pushes(int count);
		for (int i = 0; i < count; i++) begin
			add_item(MODE_PUSH, 3'($urandom_range(0, 7)), 8'($urandom));
			if ($urandom_range(0, 9) == 0)
				add_item(MODE_READ, ($urandom_range(0, 1) != 0) ? REG_IIR : REG_LSR, 8'($urandom));
		end
	endtask

	task automatic add_drain(int count);
		add_item(MODE_WRITE, REG_LCR, 8'($urandom) & 8'h7F);
		for (int i = 0; i < count; i++) begin
			add_item(MODE_READ, REG_RBR, 8'($urandom));
			if ($urandom_range(0, 7) == 0)
				add_item(MODE_READ, ($urandom_range(0, 1) != 0) ? REG_LSR : REG_IIR, 8'($urandom));
		end
	endtask

	task automatic report_mismatch(string field, int got, int want);
		// keep the log short when the block is badly broken
		if (error_count < PRINT_CAP)
			$display("mismatch at result %0d, %s: got %0h, expected %0h",
				result_count, field, got, want);
		error_count++;
	endtask

	function automatic int draw_wait(bit fast);
		return fast ? 0 : $urandom_range(0, 8);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.payload <= '0;
			send_gap = 0;
			send_fast = 1'b0;
			accepted_items <= 0;
			reset_model();
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(uart_predict(req_ch.payload));
				accepted_items <= accepted_items + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.payload <= pending_items.pop_front();
					if ($urandom_range(0, 49) == 0)
						send_fast = !send_fast;
					send_gap = draw_wait(send_fast);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off once the run is under way; the sender keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && accepted_items >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			recv_fast = 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.payload;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", int'(got), 0);
				end else begin
					want = expected_results.pop_front();
					if (got.read_data !== want.read_data)
						report_mismatch("read_data", int'(got.read_data),
							int'(want.read_data));
					if (got.irq_level !== want.irq_level)
						report_mismatch("irq_level", int'(got.irq_level),
							int'(want.irq_level));
					if (got.tx_valid !== want.tx_valid)
						report_mismatch("tx_valid", int'(got.tx_valid),
							int'(want.tx_valid));
					if (got.tx_byte !== want.tx_byte)
						report_mismatch("tx_byte", int'(got.tx_byte),
							int'(want.tx_byte));
					if (got.rx_overflow !== want.rx_overflow)
						report_mismatch("rx_overflow", int'(got.rx_overflow),
							int'(want.rx_overflow));
				end
				result_count++;
				if ($urandom_range(0, 49) == 0)
					recv_fast = !recv_fast;
				stall_left = draw_wait(recv_fast);
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", CYCLE_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		int directed_count;
		int burst;
		arst_n = 1'b0;

		// reset values, empty ring, ignored writes, transmit extremes
		add_item(MODE_READ, REG_IIR, 8'h00);
		add_item(MODE_READ, REG_LSR, 8'h00);
		add_item(MODE_READ, REG_MSR, 8'h00);
		add_item(MODE_READ, REG_RBR, 8'h00);
		add_item(MODE_WRITE, REG_LSR, 8'hFF);
		add_item(MODE_WRITE, REG_MSR, 8'hFF);
		add_item(MODE_WRITE, REG_RBR, 8'hFF);
		add_item(MODE_WRITE, REG_RBR, 8'h00);
		// interrupt priority and FIFO bits
		add_item(MODE_WRITE, REG_IER, 8'h03);
		add_item(MODE_READ, REG_IER, 8'h00);
		add_item(MODE_READ, REG_IIR, 8'h00);
		add_item(MODE_PUSH, REG_RBR, 8'hA5);
		add_item(MODE_READ, REG_IIR, 8'h00);
		add_item(MODE_READ, REG_LSR, 8'h00);
		add_item(MODE_READ, REG_RBR, 8'h00);
		add_item(MODE_WRITE, REG_IIR, 8'h01);
		add_item(MODE_READ, REG_IIR, 8'h00);
		// divisor latch through DLAB
		add_item(MODE_WRITE, REG_LCR, 8'h80);
		add_item(MODE_WRITE, REG_RBR, 8'hFF);
		add_item(MODE_WRITE, REG_IER, 8'hFF);
		add_item(MODE_READ, REG_RBR, 8'h00);
		add_item(MODE_READ, REG_IER, 8'h00);
		add_item(MODE_WRITE, REG_LCR, 8'h7F);
		add_item(MODE_WRITE, REG_SCR, 8'hFF);
		add_item(MODE_READ, REG_SCR, 8'h00);
		add_item(MODE_NOP, REG_SCR, 8'hFF);
		directed_count = pending_items.size();

		// fill past the top so the ring overflows, then drain past empty
		add_pushes(RING_DEPTH + 6);
		add_drain(RING_DEPTH + 6);

		while (pending_items.size() < directed_count + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
			0, 1: begin
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 80)
					: $urandom_range(1, 16);
				add_pushes(burst);
			end
			2, 3: begin
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70)
					: $urandom_range(1, 16);
				add_drain(burst);
			end
			4: begin
				add_item(MODE_WRITE, REG_LCR, 8'($urandom) | 8'h80);
				add_item(MODE_WRITE, REG_RBR, 8'($urandom));
				add_item(MODE_WRITE, REG_IER, 8'($urandom));
				add_item(MODE_READ, REG_RBR, 8'($urandom));
				add_item(MODE_READ, REG_IER, 8'($urandom));
				add_item(MODE_READ, REG_LCR, 8'($urandom));
				add_item(MODE_WRITE, REG_LCR, 8'($urandom) & 8'h7F);
			end
			5: begin
				add_item(MODE_WRITE, REG_LCR, 8'($urandom) & 8'h7F);
				add_item(MODE_WRITE, REG_IER, 8'($urandom));
				add_item(MODE_WRITE, REG_IIR, 8'($urandom));
				add_item(MODE_READ, REG_IIR, 8'($urandom));
				add_item(MODE_READ, REG_IER, 8'($urandom));
				add_item(MODE_READ, REG_LSR, 8'($urandom));
			end
			6: begin
				add_item(MODE_WRITE, ($urandom_range(0, 1) != 0) ? REG_SCR : REG_MCR,
					8'($urandom));
				add_item(MODE_READ, REG_SCR, 8'($urandom));
				add_item(MODE_READ, REG_MCR, 8'($urandom));
				add_item(MODE_READ, REG_MSR, 8'($urandom));
			end
			default: begin
				for (int i = 0; i < 8; i++)
					add_item(($urandom_range(0, 19) == 0) ? MODE_NOP
						: 2'($urandom_range(0, 2)), 3'($urandom), 8'($urandom));
			end
			endcase
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
